// File: rtl/ccs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the C comment stripper.
// Used by every module of the block; depends on nothing.
package ccs_pkg;

  // Bytes the scanner reacts to.
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharNl    = 8'h0A;

  // Depth of the queue between the scanner and the output side.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Item codes on the input.
  localparam logic OpText = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // Codes carried in end_status.
  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_CLOSED = 2'd1,
    ST_OPEN   = 2'd2
  } status_t;

  // Scanner modes, one-hot.
  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_SLASH  = 6'b000010,
    MODE_LINE   = 6'b000100,
    MODE_BLOCK  = 6'b001000,
    MODE_BSTAR  = 6'b010000,
    MODE_STRING = 6'b100000
  } mode_t;

  // One queue entry stands for all results of one input item. When dual is
  // set, a slash byte result goes out first; the final result is chr/status.
  typedef struct packed {
    logic    dual;
    logic [7:0] chr;
    status_t status;
  } entry_t;

endpackage

// File: rtl/ccs_front.sv
`timescale 1ns / 1ps
// Scanner: accepts input items, tracks the comment mode and turns each item
// into at most one queue entry. Depends on ccs_pkg.
module ccs_front import ccs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   op,
  input  logic [7:0] char_in,
  output logic   push_valid,
  input  logic   push_ready,
  output entry_t push_data
);

  mode_t  mode;
  mode_t  mode_next;
  logic   emit;
  entry_t ent;
  logic   accept;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && emit;
  assign push_data  = ent;

  // Next mode and the results one item causes.
  always_comb begin
    mode_next  = mode;
    emit       = 1'b0;
    ent.dual   = 1'b0;
    ent.chr    = char_in;
    ent.status = ST_BYTE;
    if (op == OpEnd) begin
      // Flush a held slash, then report whether a block comment is open.
      emit       = 1'b1;
      ent.dual   = (mode == MODE_SLASH);
      ent.chr    = 8'h00;
      ent.status = (mode == MODE_BLOCK || mode == MODE_BSTAR) ? ST_OPEN : ST_CLOSED;
      mode_next  = MODE_NORMAL;
    end else begin
      case (mode)
        MODE_SLASH: begin
          if (char_in == CharSlash) begin
            mode_next = MODE_LINE;
          end else if (char_in == CharStar) begin
            mode_next = MODE_BLOCK;
          end else begin
            emit      = 1'b1;
            ent.dual  = 1'b1;
            mode_next = (char_in == CharQuote) ? MODE_STRING : MODE_NORMAL;
          end
        end
        MODE_LINE: begin
          if (char_in == CharNl) begin
            emit      = 1'b1;
            mode_next = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (char_in == CharStar) begin
            mode_next = MODE_BSTAR;
          end else if (char_in == CharNl) begin
            emit = 1'b1;
          end
        end
        MODE_BSTAR: begin
          if (char_in == CharSlash) begin
            mode_next = MODE_NORMAL;
          end else if (char_in != CharStar) begin
            emit      = (char_in == CharNl);
            mode_next = MODE_BLOCK;
          end
        end
        MODE_STRING: begin
          emit = 1'b1;
          if (char_in == CharQuote) begin
            mode_next = MODE_NORMAL;
          end
        end
        default: begin
          // Normal text.
          if (char_in == CharSlash) begin
            mode_next = MODE_SLASH;
          end else begin
            emit      = 1'b1;
            mode_next = (char_in == CharQuote) ? MODE_STRING : MODE_NORMAL;
          end
        end
      endcase
    end
  end

  // Mode register advances on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

// File: rtl/ccs_queue.sv
`timescale 1ns / 1ps
// Small register queue of result entries between scanner and output side.
// Depends on ccs_pkg.
module ccs_queue import ccs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  entry_t                slots [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr;
  logic [QueuePtrW-1:0]  rd_ptr;
  logic [QueueCntW-1:0]  count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != QueueCntW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QueueCntW'(1);
      end
    end
  end

endmodule

// File: rtl/ccs_back.sv
`timescale 1ns / 1ps
// Output side: expands queue entries into one or two results and holds each
// in an output register until the receiver takes it. Depends on ccs_pkg.
module ccs_back import ccs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  entry_t pop_data,
  output logic   out_valid,
  input  logic   out_ready,
  output logic [7:0] char_out,
  output logic   is_last,
  output logic [1:0] end_status
);

  logic load;
  logic half;
  logic lead;

  // The output register can take a new result when empty or being drained.
  assign load      = !out_valid || out_ready;
  // A dual entry first sends its leading slash and stays at the queue head.
  assign lead      = pop_data.dual && !half;
  assign pop_ready = load && !lead;

  // Control: output valid and the half-done flag of a dual entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      out_valid <= pop_valid;
      if (pop_valid) begin
        half <= lead;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      if (lead) begin
        char_out   <= CharSlash;
        is_last    <= 1'b0;
        end_status <= ST_BYTE;
      end else begin
        char_out   <= pop_data.chr;
        is_last    <= 1'b1;
        end_status <= pop_data.status;
      end
    end
  end

endmodule

// File: rtl/c_comment_stripper.sv
`timescale 1ns / 1ps
// C comment stripper top level.
// Input channel: in_valid/in_ready with op (0 text byte, 1 end marker) and
// char_in. Output channel: out_valid/out_ready with char_out, is_last and
// end_status (0 byte, 1 end with comments closed, 2 end with a block open).
// A scanner takes one input transfer per cycle while the queue has room and
// writes the results of each item as one entry into a four-entry queue; the
// output side reads the queue and presents one result per cycle from an
// output register while the receiver is ready. Each result passes through the
// queue and then the output register. Throughput: one item per cycle while
// the queue has room; an item with two results (a slash followed by ordinary
// text, or an end marker after a held slash) sends them out one at a time,
// and items with no result (comment bytes) cost nothing on the output.
// When the receiver stalls, results wait in the output register and the
// queue; once the queue is full, in_ready drops until room frees up.
// Reset (synchronous, rst high) empties the queue and output register and
// returns the scanner to normal text; no clearing pass is needed.
// Depends on ccs_pkg, ccs_front, ccs_queue and ccs_back.
module c_comment_stripper import ccs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out,
  output logic       is_last,
  output logic [1:0] end_status
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  // Scanner.
  ccs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .char_in    (char_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue.
  ccs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Output side.
  ccs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .is_last    (is_last),
    .end_status (end_status)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for c_comment_stripper: directed rows, then random source text.
// Depends on ccs_pkg (status codes, scanner modes, special bytes) and the block's RTL.
module tb;
  import ccs_pkg::*;

  // One expected output transfer.
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    status_t    st;
  } result_t;

  // One directed row; n_res < 0 means the predictor supplies the results.
  typedef struct {
    logic       is_end;
    logic [7:0] chr;
    int         n_res;
    result_t    r0;
    result_t    r1;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = OpText;
  logic [7:0] char_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] char_out;
  logic       is_last;
  logic [1:0] end_status;

  mode_t      scan_mode_q = MODE_NORMAL;
  result_t    expected_out[$];
  stim_row_t  stim[$];
  int         items_fed = 0;
  int         bad_results = 0;
  bit         tx_burst = 1'b0;
  bit         rx_burst = 1'b0;

  c_comment_stripper u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .is_last    (is_last),
    .end_status (end_status)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t byte_res(input logic [7:0] c, input logic last = 1'b0);
    result_t r;
    r.chr = c;
    r.last = last;
    r.st = ST_BYTE;
    return r;
  endfunction

  function automatic result_t end_res(input status_t st);
    result_t r;
    r.chr = 8'h00;
    r.last = 1'b1;
    r.st = st;
    return r;
  endfunction

  function automatic void row(input logic is_end, input logic [7:0] c, input int n = -1,
                              input result_t r0 = '0, input result_t r1 = '0);
    stim_row_t s;
    s.is_end = is_end;
    s.chr = c;
    s.n_res = n;
    s.r0 = r0;
    s.r1 = r1;
    stim.push_back(s);
  endfunction

  // Scanner prediction: advances the mode and returns the results of one item.
  function automatic void scan_predict(input logic o, input logic [7:0] c,
                                       output result_t got[$]);
    mode_t m;
    got = {};
    m = scan_mode_q;
    if (o == OpEnd) begin
      // A held slash is flushed before the status.
      if (m == MODE_SLASH) got.push_back(byte_res(CharSlash));
      got.push_back(end_res((m == MODE_BLOCK || m == MODE_BSTAR) ? ST_OPEN : ST_CLOSED));
      m = MODE_NORMAL;
    end else begin
      case (m)
        MODE_SLASH: begin
          if (c == CharSlash) begin
            m = MODE_LINE;
          end else if (c == CharStar) begin
            m = MODE_BLOCK;
          end else begin
            got.push_back(byte_res(CharSlash));
            got.push_back(byte_res(c));
            m = (c == CharQuote) ? MODE_STRING : MODE_NORMAL;
          end
        end
        MODE_LINE: begin
          if (c == CharNl) begin
            got.push_back(byte_res(c));
            m = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (c == CharStar) m = MODE_BSTAR;
          else if (c == CharNl) got.push_back(byte_res(c));
        end
        MODE_BSTAR: begin
          // Further stars keep the star-seen mode; any other byte but a slash drops back to the block.
          if (c == CharSlash) begin
            m = MODE_NORMAL;
          end else if (c != CharStar) begin
            if (c == CharNl) got.push_back(byte_res(c));
            m = MODE_BLOCK;
          end
        end
        MODE_STRING: begin
          got.push_back(byte_res(c));
          if (c == CharQuote) m = MODE_NORMAL;
        end
        default: begin
          if (c == CharSlash) begin
            m = MODE_SLASH;
          end else begin
            got.push_back(byte_res(c));
            m = (c == CharQuote) ? MODE_STRING : MODE_NORMAL;
          end
        end
      endcase
    end
    if (got.size() > 0) got[got.size() - 1].last = 1'b1;
    scan_mode_q = m;
  endfunction

  // Drives one input transfer and queues its expected results once accepted.
  task automatic feed_byte(input logic o, input logic [7:0] c, input int n_fixed = -1,
                           input result_t f0 = '0, input result_t f1 = '0);
    int      gap;
    result_t got[$];
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_fed++;
    scan_predict(o, c, got);
    if (n_fixed < 0) begin
      foreach (got[i]) expected_out.push_back(got[i]);
    end else begin
      if (n_fixed > 0) expected_out.push_back(f0);
      if (n_fixed > 1) expected_out.push_back(f1);
    end
  endtask

  // Byte drawn with a bias toward the bytes the scanner reacts to.
  function automatic logic [7:0] pick_byte(input int special_pct);
    if ($urandom_range(0, 99) < special_pct) begin
      case ($urandom_range(0, 3))
        0: return CharSlash;
        1: return CharStar;
        2: return CharQuote;
        default: return CharNl;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // One fragment of source text: mostly well-formed constructs with random bodies.
  task automatic feed_snippet();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    len = $urandom_range(0, 8);
    if (kind < 25) begin
      repeat (len + 1) feed_byte(OpText, pick_byte(20));
    end else if (kind < 45) begin
      feed_byte(OpText, CharSlash);
      feed_byte(OpText, CharSlash);
      repeat (len) feed_byte(OpText, pick_byte(30));
      feed_byte(OpText, CharNl);
    end else if (kind < 65) begin
      feed_byte(OpText, CharSlash);
      feed_byte(OpText, CharStar);
      repeat (len) feed_byte(OpText, pick_byte(50));
      repeat ($urandom_range(1, 3)) feed_byte(OpText, CharStar);
      feed_byte(OpText, CharSlash);
    end else if (kind < 80) begin
      feed_byte(OpText, CharQuote);
      repeat (len) feed_byte(OpText, pick_byte(30));
      feed_byte(OpText, CharQuote);
    end else if (kind < 90) begin
      feed_byte(OpText, CharSlash);
      feed_byte(OpText, pick_byte(60));
    end else if (kind < 95) begin
      feed_byte(OpEnd, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) feed_byte(OpText, pick_byte(90));
    end
  endtask

  // Main sequence: reset, directed rows, random text, drain.
  initial begin
    // Plain bytes and extremes straight after reset.
    row(OpText, "A", 1, byte_res("A", 1'b1));
    row(OpText, 8'h00, 1, byte_res(8'h00, 1'b1));
    row(OpText, 8'hFF, 1, byte_res(8'hFF, 1'b1));
    // Slash then ordinary byte gives two results.
    row(OpText, CharSlash, 0);
    row(OpText, "x", 2, byte_res(CharSlash), byte_res("x", 1'b1));
    // Line comment, newline passes.
    row(OpText, CharSlash);
    row(OpText, CharSlash);
    row(OpText, CharStar);
    row(OpText, CharNl);
    // Block comment with repeated stars and a newline after a star.
    row(OpText, CharSlash);
    row(OpText, CharStar);
    row(OpText, CharStar);
    row(OpText, CharStar);
    row(OpText, CharNl);
    row(OpText, CharSlash);
    row(OpText, CharStar);
    row(OpText, CharSlash);
    // Quoted text passes comment openers untouched.
    row(OpText, CharQuote);
    row(OpText, CharSlash);
    row(OpText, CharStar);
    row(OpText, CharQuote);
    // Slash then quote opens quoted text; an end marker there counts as closed.
    row(OpText, CharSlash);
    row(OpText, CharQuote);
    row(OpEnd, 8'hFF, 1, end_res(ST_CLOSED));
    // Slash then newline.
    row(OpText, CharSlash);
    row(OpText, CharNl);
    // End marker flushes a held slash.
    row(OpText, CharSlash);
    row(OpEnd, 8'h00, 2, byte_res(CharSlash), end_res(ST_CLOSED));
    // End marker inside an open block comment.
    row(OpText, CharSlash);
    row(OpText, CharStar);
    row(OpEnd, 8'h5A, 1, end_res(ST_OPEN));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (stim[i]) feed_byte(stim[i].is_end, stim[i].chr, stim[i].n_res, stim[i].r0,
                                stim[i].r1);
    while (items_fed < 1880) feed_snippet();
    in_valid <= 1'b0;

    // Wait for every expected result, then watch a little longer for strays.
    while (expected_out.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (bad_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random stall before each output transfer, with stall-free stretches.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Output check against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: char_out %h is_last %b end_status %0d",
                   char_out, is_last, end_status);
      end else begin
        want = expected_out.pop_front();
        if (char_out !== want.chr || is_last !== want.last || end_status !== want.st) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: char_out %h/%h is_last %b/%b end_status %0d/%0d (exp/act)",
                     want.chr, char_out, want.last, is_last, want.st, end_status);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
